/* rtl/pss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg : packet switch scheduler shared definitions
// Default sizes, result kinds, register indexes, controller states, datapath
// operations and the command and status bundles between the two halves.
// ----------------------------------------------------------------------------
package pss_pkg;

   // default switch size
   localparam int PSS_PORTS       = 8;
   localparam int PSS_QUEUE_DEPTH = 16;

   // fixed field widths
   localparam int PORT_W = 3;
   localparam int SLOT_W = 32;
   localparam int KIND_W = 2;
   localparam int CSR_W  = 5;
   localparam int CSR_IW = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEPART  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

   // register indexes
   localparam logic [CSR_IW-1:0] CFG_MODE   = 2'd0;
   localparam logic [CSR_IW-1:0] CFG_KNOCK  = 2'd1;
   localparam logic [CSR_IW-1:0] CFG_QLIMIT = 2'd2;

   // register reset values
   localparam logic [CSR_W-1:0] KNOCK_RESET  = 5'd1;
   localparam logic [CSR_W-1:0] QLIMIT_RESET = 5'd16;

   // controller states
   typedef enum logic [4:0] {
      S_IDLE,
      S_ARRIVE,
      S_TICK,
      S_DEP_CHK,
      S_DEP_WAIT,
      S_DEP_EMIT,
      S_SCHED,
      S_KO_CHK,
      S_KO_TEST,
      S_KO_NEXT,
      S_KO_END,
      S_FF_ROW,
      S_FF_READ,
      S_FF_TEST,
      S_FF_SHRD,
      S_FF_SHWR,
      S_FF_NEXT,
      S_SUM
   } state_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_ARRIVE,
      OP_TICK_START,
      OP_DEP_READ,
      OP_DEP_EMIT,
      OP_O_NEXT,
      OP_KO_INIT,
      OP_KO_READ,
      OP_KO_TEST,
      OP_I_NEXT,
      OP_KO_END,
      OP_FF_INIT,
      OP_FF_ROW,
      OP_FF_READ,
      OP_FF_TEST,
      OP_FF_SHRD,
      OP_FF_SHWR,
      OP_SUMMARY
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic out_free;
      logic ocnt_nz;
      logic icnt_nz;
      logic o_last;
      logic i_last;
      logic ff_free;
      logic j_end;
   } status_type;

endpackage

/* rtl/packet_switch_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_switch_scheduler : input-queued crossbar scheduler
// Queues arriving packets per input, sends output queue heads on each slot
// tick and moves packets by knockout or first-fit scheduling.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | cmd, in_port, dest_port
//  rsp_    | out       | rsp_valid/rsp_ready  | kind .. last, one request gives 1..PORTS+1
//  csr_    | in        | csr_write            | csr_index, csr_wdata
//
// an arrival is accepted, then written to its queue with its result registered.
// a tick advances the slot, sends the head of each non-empty output queue,
// then runs the scheduling walk: knockout over each output and input, or
// first-fit over each input's packets, shifting out each one taken or lost.
// one request is in flight at a time; a result stall holds the sequencer.
// reset is synchronous and empties every queue and counter.
module packet_switch_scheduler #(
   parameter int PORTS       = pss_pkg::PSS_PORTS,
   parameter int QUEUE_DEPTH = pss_pkg::PSS_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [pss_pkg::PORT_W-1:0]  req_in_port,
   input  logic [pss_pkg::PORT_W-1:0]  req_dest_port,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pss_pkg::KIND_W-1:0]  rsp_kind,
   output logic [pss_pkg::PORT_W-1:0]  rsp_port_out,
   output logic [pss_pkg::PORT_W-1:0]  rsp_src_port,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_arrival_slot,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_delay,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_contention_total,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_lost_total,
   output logic                        rsp_last,
   input  logic                        csr_write,
   input  logic [pss_pkg::CSR_IW-1:0]  csr_index,
   input  logic [pss_pkg::CSR_W-1:0]   csr_wdata
);
   import pss_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // queues and counters
   pss_datapath #(
      .PORTS       (PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_cmd              (req_cmd),
      .req_in_port          (req_in_port),
      .req_dest_port        (req_dest_port),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_port_out         (rsp_port_out),
      .rsp_src_port         (rsp_src_port),
      .rsp_arrival_slot     (rsp_arrival_slot),
      .rsp_delay            (rsp_delay),
      .rsp_contention_total (rsp_contention_total),
      .rsp_lost_total       (rsp_lost_total),
      .rsp_last             (rsp_last)
   );

endmodule

/* rtl/pss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_ctrl : scheduler sequencer
// Walks arrivals, departures and the selected scheduling pass, issuing at most one
// datapath operation per cycle and holding while the result register is busy.
// ----------------------------------------------------------------------------
module pss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_cmd,
   output logic                req_ready,
   input  pss_pkg::status_type status,
   output pss_pkg::cmd_type    cmd
);
   import pss_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and operation
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = req_cmd ? S_TICK : S_ARRIVE;
            end
         end
         S_ARRIVE: begin
            if (status.out_free) begin
               cmd.op   = OP_ARRIVE;
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            cmd.op   = OP_TICK_START;
            state_in = S_DEP_CHK;
         end
         S_DEP_CHK: begin
            if (status.ocnt_nz) begin
               cmd.op   = OP_DEP_READ;
               state_in = S_DEP_WAIT;
            end else begin
               cmd.op   = OP_O_NEXT;
               state_in = status.o_last ? S_SCHED : S_DEP_CHK;
            end
         end
         S_DEP_WAIT: begin
            state_in = S_DEP_EMIT;
         end
         S_DEP_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_DEP_EMIT;
               state_in = status.o_last ? S_SCHED : S_DEP_CHK;
            end
         end
         S_SCHED: begin
            cmd.op   = status.mode ? OP_FF_INIT : OP_KO_INIT;
            state_in = status.mode ? S_FF_ROW : S_KO_CHK;
         end
         S_KO_CHK: begin
            if (status.icnt_nz) begin
               cmd.op   = OP_KO_READ;
               state_in = S_KO_TEST;
            end else begin
               state_in = S_KO_NEXT;
            end
         end
         S_KO_TEST: begin
            cmd.op   = OP_KO_TEST;
            state_in = S_KO_NEXT;
         end
         S_KO_NEXT: begin
            if (status.i_last) begin
               state_in = S_KO_END;
            end else begin
               cmd.op   = OP_I_NEXT;
               state_in = S_KO_CHK;
            end
         end
         S_KO_END: begin
            cmd.op   = OP_KO_END;
            state_in = status.o_last ? S_SUM : S_KO_CHK;
         end
         S_FF_ROW: begin
            if (status.icnt_nz) begin
               cmd.op   = OP_FF_ROW;
               state_in = S_FF_READ;
            end else begin
               state_in = S_FF_NEXT;
            end
         end
         S_FF_READ: begin
            cmd.op   = OP_FF_READ;
            state_in = S_FF_TEST;
         end
         S_FF_TEST: begin
            cmd.op = OP_FF_TEST;
            priority if (status.ff_free) begin
               state_in = S_FF_SHRD;
            end else if (status.j_end) begin
               state_in = S_FF_NEXT;
            end else begin
               state_in = S_FF_READ;
            end
         end
         S_FF_SHRD: begin
            cmd.op   = OP_FF_SHRD;
            state_in = status.j_end ? S_FF_NEXT : S_FF_SHWR;
         end
         S_FF_SHWR: begin
            cmd.op   = OP_FF_SHWR;
            state_in = S_FF_SHRD;
         end
         S_FF_NEXT: begin
            if (status.i_last) begin
               state_in = S_SUM;
            end else begin
               cmd.op   = OP_I_NEXT;
               state_in = S_FF_ROW;
            end
         end
         S_SUM: begin
            if (status.out_free) begin
               cmd.op   = OP_SUMMARY;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/pss_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_datapath : queues, counters and response register
// Input and output queues live in two memories as circular buffers per port.
// Each operation from the sequencer touches at most one entry of each.
// ----------------------------------------------------------------------------
module pss_datapath #(
   parameter int PORTS       = pss_pkg::PSS_PORTS,
   parameter int QUEUE_DEPTH = pss_pkg::PSS_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pss_pkg::cmd_type            cmd,
   output pss_pkg::status_type         status,
   input  logic                        req_cmd,
   input  logic [pss_pkg::PORT_W-1:0]  req_in_port,
   input  logic [pss_pkg::PORT_W-1:0]  req_dest_port,
   input  logic                        csr_write,
   input  logic [pss_pkg::CSR_IW-1:0]  csr_index,
   input  logic [pss_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [pss_pkg::KIND_W-1:0]  rsp_kind,
   output logic [pss_pkg::PORT_W-1:0]  rsp_port_out,
   output logic [pss_pkg::PORT_W-1:0]  rsp_src_port,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_arrival_slot,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_delay,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_contention_total,
   output logic [pss_pkg::SLOT_W-1:0]  rsp_lost_total,
   output logic                        rsp_last
);
   import pss_pkg::*;

   localparam int PW        = $clog2(PORTS);
   localparam int IDXW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int CNW       = $clog2(PORTS + 1);
   localparam int EW        = PW + SLOT_W;
   localparam int AW        = PW + IDXW;
   localparam int MEM_DEPTH = PORTS * (2 ** IDXW);

   // queue memories: entry is {port, stamp}
   logic [EW-1:0] imem [MEM_DEPTH];
   logic [EW-1:0] omem [MEM_DEPTH];
   logic          imem_we, imem_re, omem_we, omem_re;
   logic [AW-1:0] imem_waddr, imem_raddr, omem_waddr, omem_raddr;
   logic [EW-1:0] imem_wdata, omem_wdata;
   logic [EW-1:0] irdata_ff, ordata_ff;

   // configuration
   logic             mode_ff, mode_in;
   logic [CSR_W-1:0] knock_ff, knock_in, qlim_ff, qlim_in;

   // walk indices and per-slot bookkeeping
   logic [PW-1:0]    i_ff, i_in, o_ff, o_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CNW-1:0]   cn_ff, cn_in, g_ff, g_in;
   logic [PORTS-1:0] claimed_ff, claimed_in;
   logic [PORT_W-1:0] dp_ff, dp_in;
   logic             ok_ff, ok_in;

   // counters
   logic [SLOT_W-1:0] slot_ff, slot_in, cont_ff, cont_in, lost_ff, lost_in;

   // queue pointers
   logic [IDXW-1:0] ihead_ff [PORTS];
   logic [IDXW-1:0] ihead_in [PORTS];
   logic [CW-1:0]   icnt_ff  [PORTS];
   logic [CW-1:0]   icnt_in  [PORTS];
   logic [IDXW-1:0] ohead_ff [PORTS];
   logic [IDXW-1:0] ohead_in [PORTS];
   logic [CW-1:0]   ocnt_ff  [PORTS];
   logic [CW-1:0]   ocnt_in  [PORTS];

   // response register
   logic              rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [KIND_W-1:0] rkind_ff, rkind_in;
   logic [PORT_W-1:0] rpo_ff, rpo_in, rsp_ff, rsp_in;
   logic [SLOT_W-1:0] rarr_ff, rarr_in, rdly_ff, rdly_in;
   logic [SLOT_W-1:0] rct_ff, rct_in, rlt_ff, rlt_in;

   // helper signals
   logic [CW-1:0]     lim;
   logic [PW-1:0]     ir_port, or_port, oq;
   logic [SLOT_W-1:0] ir_stamp, or_stamp;
   logic [IDXW-1:0]   ihead_i, ohead_q;
   logic [CW-1:0]     icnt_i, ocnt_q;
   logic              ofull, out_free, j_end;

   // circular index add
   function automatic logic [IDXW-1:0] wrap(input logic [IDXW-1:0] head,
                                            input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW + 1)'(head) + (CW + 1)'(off);
      if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
         s = s - (CW + 1)'(QUEUE_DEPTH);
      end
      return IDXW'(s);
   endfunction

   assign ir_port  = irdata_ff[EW-1:SLOT_W];
   assign ir_stamp = irdata_ff[SLOT_W-1:0];
   assign or_port  = ordata_ff[EW-1:SLOT_W];
   assign or_stamp = ordata_ff[SLOT_W-1:0];
   assign oq       = (cmd.op == OP_FF_TEST) ? ir_port : o_ff;
   assign ihead_i  = ihead_ff[i_ff];
   assign icnt_i   = icnt_ff[i_ff];
   assign ohead_q  = ohead_ff[oq];
   assign ocnt_q   = ocnt_ff[oq];
   assign lim      = (32'(qlim_ff) < QUEUE_DEPTH) ? CW'(qlim_ff) : CW'(QUEUE_DEPTH);
   assign ofull    = (ocnt_q >= lim);
   assign out_free = !rvalid_ff || rsp_ready;
   assign j_end    = (({1'b0, j_ff} + (CW + 1)'(1)) >= {1'b0, icnt_i});

   // status to the sequencer
   always_comb begin
      status.mode     = mode_ff;
      status.out_free = out_free;
      status.ocnt_nz  = (ocnt_ff[o_ff] != '0);
      status.icnt_nz  = (icnt_i != '0);
      status.o_last   = (32'(o_ff) == PORTS - 1);
      status.i_last   = (32'(i_ff) == PORTS - 1);
      status.ff_free  = !claimed_ff[ir_port];
      status.j_end    = j_end;
   end

   // operation decode
   always_comb begin
      mode_in    = mode_ff;
      knock_in   = knock_ff;
      qlim_in    = qlim_ff;
      i_in       = i_ff;
      o_in       = o_ff;
      j_in       = j_ff;
      cn_in      = cn_ff;
      g_in       = g_ff;
      claimed_in = claimed_ff;
      dp_in      = dp_ff;
      ok_in      = ok_ff;
      slot_in    = slot_ff;
      cont_in    = cont_ff;
      lost_in    = lost_ff;
      ihead_in   = ihead_ff;
      icnt_in    = icnt_ff;
      ohead_in   = ohead_ff;
      ocnt_in    = ocnt_ff;
      rvalid_in  = rvalid_ff && !rsp_ready;
      rkind_in   = rkind_ff;
      rpo_in     = rpo_ff;
      rsp_in     = rsp_ff;
      rarr_in    = rarr_ff;
      rdly_in    = rdly_ff;
      rct_in     = rct_ff;
      rlt_in     = rlt_ff;
      rlast_in   = rlast_ff;
      imem_we    = 1'b0;
      imem_re    = 1'b0;
      omem_we    = 1'b0;
      omem_re    = 1'b0;
      imem_waddr = {i_ff, wrap(ihead_i, icnt_i)};
      imem_raddr = {i_ff, ihead_i};
      omem_waddr = {oq, wrap(ohead_q, ocnt_q)};
      omem_raddr = {o_ff, ohead_q};
      imem_wdata = {PW'(dp_ff), slot_ff};
      omem_wdata = {i_ff, ir_stamp};

      // register writes
      if (csr_write) begin
         unique case (csr_index)
            CFG_MODE:   mode_in  = csr_wdata[0];
            CFG_KNOCK:  knock_in = csr_wdata;
            CFG_QLIMIT: qlim_in  = csr_wdata;
            default:    ;
         endcase
      end

      unique case (cmd.op)
         OP_ACCEPT: begin
            i_in  = PW'(req_in_port);
            dp_in = req_dest_port;
            ok_in = !req_cmd && (32'(req_in_port) < PORTS) && (32'(req_dest_port) < PORTS);
         end
         OP_ARRIVE: begin
            rvalid_in = 1'b1;
            rpo_in    = '0;
            rsp_in    = '0;
            rarr_in   = '0;
            rdly_in   = '0;
            rct_in    = '0;
            rlt_in    = '0;
            rlast_in  = 1'b1;
            if (ok_ff && (icnt_i < lim)) begin
               imem_we         = 1'b1;
               icnt_in[i_ff]   = icnt_i + CW'(1);
               rkind_in        = KIND_ACCEPT;
            end else begin
               rkind_in        = KIND_DROP;
            end
         end
         OP_TICK_START: begin
            slot_in = slot_ff + SLOT_W'(1);
            o_in    = '0;
         end
         OP_DEP_READ: begin
            omem_re = 1'b1;
         end
         OP_DEP_EMIT: begin
            rvalid_in     = 1'b1;
            rkind_in      = KIND_DEPART;
            rpo_in        = PORT_W'(o_ff);
            rsp_in        = PORT_W'(or_port);
            rarr_in       = or_stamp;
            rdly_in       = slot_ff - or_stamp;
            rct_in        = '0;
            rlt_in        = '0;
            rlast_in      = 1'b0;
            ohead_in[o_ff] = wrap(ohead_q, CW'(1));
            ocnt_in[o_ff]  = ocnt_q - CW'(1);
            o_in           = o_ff + PW'(1);
         end
         OP_O_NEXT: begin
            o_in = o_ff + PW'(1);
         end
         OP_KO_INIT: begin
            o_in  = '0;
            i_in  = '0;
            cn_in = '0;
            g_in  = '0;
         end
         OP_KO_READ: begin
            imem_re = 1'b1;
         end
         OP_KO_TEST: begin
            // head bound for this output: count the request, grant if under the knockout limit and the queue has room
            if (ir_port == o_ff) begin
               cn_in = cn_ff + CNW'(1);
               if ((32'(g_ff) < 32'(knock_ff)) && !ofull) begin
                  omem_we        = 1'b1;
                  ocnt_in[o_ff]  = ocnt_q + CW'(1);
                  ihead_in[i_ff] = wrap(ihead_i, CW'(1));
                  icnt_in[i_ff]  = icnt_i - CW'(1);
                  g_in           = g_ff + CNW'(1);
               end
            end
         end
         OP_I_NEXT: begin
            i_in = i_ff + PW'(1);
         end
         OP_KO_END: begin
            if (32'(cn_ff) > 32'(knock_ff)) begin
               cont_in = cont_ff + SLOT_W'(1);
            end
            o_in  = o_ff + PW'(1);
            i_in  = '0;
            cn_in = '0;
            g_in  = '0;
         end
         OP_FF_INIT: begin
            i_in       = '0;
            claimed_in = '0;
         end
         OP_FF_ROW: begin
            j_in = '0;
         end
         OP_FF_READ: begin
            imem_re    = 1'b1;
            imem_raddr = {i_ff, wrap(ihead_i, j_ff)};
         end
         OP_FF_TEST: begin
            // oldest packet whose output is still free wins it
            if (!claimed_ff[ir_port]) begin
               claimed_in[ir_port] = 1'b1;
               if (!ofull) begin
                  omem_we          = 1'b1;
                  ocnt_in[ir_port] = ocnt_q + CW'(1);
               end else begin
                  lost_in = lost_ff + SLOT_W'(1);
               end
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         OP_FF_SHRD: begin
            // close the gap left by the taken packet
            if (j_end) begin
               icnt_in[i_ff] = icnt_i - CW'(1);
            end else begin
               imem_re    = 1'b1;
               imem_raddr = {i_ff, wrap(ihead_i, j_ff + CW'(1))};
            end
         end
         OP_FF_SHWR: begin
            imem_we    = 1'b1;
            imem_waddr = {i_ff, wrap(ihead_i, j_ff)};
            imem_wdata = irdata_ff;
            j_in       = j_ff + CW'(1);
         end
         OP_SUMMARY: begin
            rvalid_in = 1'b1;
            rkind_in  = KIND_SUMMARY;
            rpo_in    = '0;
            rsp_in    = '0;
            rarr_in   = '0;
            rdly_in   = '0;
            rct_in    = cont_ff;
            rlt_in    = lost_ff;
            rlast_in  = 1'b1;
         end
         default: ;
      endcase
   end

   // queue memories
   always_ff @(posedge clock) begin
      if (imem_we) begin
         imem[imem_waddr] <= imem_wdata;
      end
      if (imem_re) begin
         irdata_ff <= imem[imem_raddr];
      end
      if (omem_we) begin
         omem[omem_waddr] <= omem_wdata;
      end
      if (omem_re) begin
         ordata_ff <= omem[omem_raddr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         knock_ff  <= KNOCK_RESET;
         qlim_ff   <= QLIMIT_RESET;
         slot_ff   <= '0;
         cont_ff   <= '0;
         lost_ff   <= '0;
         rvalid_ff <= 1'b0;
         i_ff      <= '0;
         o_ff      <= '0;
         j_ff      <= '0;
         cn_ff     <= '0;
         g_ff      <= '0;
         claimed_ff <= '0;
         ok_ff     <= 1'b0;
         for (int p = 0; p < PORTS; p++) begin
            ihead_ff[p] <= '0;
            icnt_ff[p]  <= '0;
            ohead_ff[p] <= '0;
            ocnt_ff[p]  <= '0;
         end
      end else begin
         mode_ff    <= mode_in;
         knock_ff   <= knock_in;
         qlim_ff    <= qlim_in;
         slot_ff    <= slot_in;
         cont_ff    <= cont_in;
         lost_ff    <= lost_in;
         rvalid_ff  <= rvalid_in;
         i_ff       <= i_in;
         o_ff       <= o_in;
         j_ff       <= j_in;
         cn_ff      <= cn_in;
         g_ff       <= g_in;
         claimed_ff <= claimed_in;
         ok_ff      <= ok_in;
         ihead_ff   <= ihead_in;
         icnt_ff    <= icnt_in;
         ohead_ff   <= ohead_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dp_ff    <= dp_in;
      rkind_ff <= rkind_in;
      rpo_ff   <= rpo_in;
      rsp_ff   <= rsp_in;
      rarr_ff  <= rarr_in;
      rdly_ff  <= rdly_in;
      rct_ff   <= rct_in;
      rlt_ff   <= rlt_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid            = rvalid_ff;
   assign rsp_kind             = rkind_ff;
   assign rsp_port_out         = rpo_ff;
   assign rsp_src_port         = rsp_ff;
   assign rsp_arrival_slot     = rarr_ff;
   assign rsp_delay            = rdly_ff;
   assign rsp_contention_total = rct_ff;
   assign rsp_lost_total       = rlt_ff;
   assign rsp_last             = rlast_ff;

endmodule
